[rtl/core/spq_pkg.sv]
// Package: shared types, constants and status codes of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Number of cells in the chain
    localparam int QUEUE_DEPTH = 16;
    // Internal entry counter width, able to hold QUEUE_DEPTH itself
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the item channels
    localparam int HANDLE_W    = 32;
    localparam int KIND_W      = 16;
    localparam int PRIO_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 5;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_NULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    // One stored entry
    typedef struct packed {
        logic [HANDLE_W-1:0]      handle;
        logic [KIND_W-1:0]        kind;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic   insert;  // committed insert this cycle
        logic   remove;  // committed remove this cycle
        t_entry req;     // entry carried by the command
    } t_cell_ctl;

endpackage

[rtl/core/spq_if.sv]
// Interfaces: command and result channels of the stable priority queue.
`timescale 1ns / 1ps

interface spq_cmd_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [HANDLE_W-1:0]      item_handle;
    logic [KIND_W-1:0]        item_kind;
    logic signed [PRIO_W-1:0] priority_req;

    modport source (output valid, cmd, item_handle, item_kind, priority_req, input ready);
    modport sink   (input valid, cmd, item_handle, item_kind, priority_req, output ready);
endinterface

interface spq_res_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic [HANDLE_W-1:0]      out_handle;
    logic [KIND_W-1:0]        out_kind;
    logic signed [PRIO_W-1:0] out_priority;

    modport source (output valid, status, count, out_handle, out_kind, out_priority,
                    input ready);
    modport sink   (input valid, status, count, out_handle, out_kind, out_priority,
                    output ready);
endinterface

[rtl/core/stable_priority_queue_core.sv]
// Top level: stable minimum-priority queue built from a chain of sorted cells.
//
// Usage:
//   Commands arrive on i_cmd (valid/ready); each yields exactly one result item
//   on o_res (valid/ready). An insert places the entry after every stored entry
//   of lower or equal priority; a remove returns the head entry.
//   Inserts are rejected for a null handle, a handle already stored, or a full
//   queue, checked in that order. A remove on an empty queue reports empty.
//   Every result carries the entry count after the command.
// Throughput and timing:
//   One item per cycle while results are taken. A command accepted at one edge
//   has its result valid after that edge. All cells compare and shift in the
//   same cycle, so the duplicate search and the insert point settle within it.
// Stall:
//   The result register frees as the receiver takes it; while it holds an
//   untaken result, i_cmd.ready stays low and the queue state holds.
// Reset:
//   Synchronous, active low. Clears the entry count and the result valid;
//   cell contents are left as they are and are never read until written.
`timescale 1ns / 1ps

module stable_priority_queue_core
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    spq_cmd_if.sink   i_cmd,
    spq_res_if.source o_res
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_res_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [CNT_W-1:0]         r_res_count;
    t_entry                   r_res_entry;
    t_entry                   n_res_entry;

    t_cell_ctl                w_ctl;
    t_entry                   w_req;
    logic                     w_accept;
    logic                     w_dup;
    logic                     w_full;
    logic [QUEUE_DEPTH-1:0]   w_occ;
    logic [QUEUE_DEPTH-1:0]   w_gt;
    logic [QUEUE_DEPTH-1:0]   w_match;
    t_entry                   w_entry [QUEUE_DEPTH];

    // Accept when the result register is free or being drained
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_req.handle = i_cmd.item_handle;
    assign w_req.kind   = i_cmd.item_kind;
    assign w_req.prio   = i_cmd.priority_req;

    assign w_dup  = |w_match;
    assign w_full = (r_count == CNT_W'(QUEUE_DEPTH));

    // Decide the command outcome
    always_comb begin
        n_status    = ST_OK;
        n_count     = r_count;
        n_res_entry = '0;
        w_ctl       = '0;
        w_ctl.req   = w_req;
        if (i_cmd.cmd == CMD_REMOVE) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_res_entry  = w_entry[0];
                n_count      = r_count - CNT_W'(1);
                w_ctl.remove = w_accept;
            end
        end else begin
            if (i_cmd.item_handle == '0) begin
                n_status = ST_NULL;
            end else if (w_dup) begin
                n_status = ST_DUP;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count      = r_count + CNT_W'(1);
                w_ctl.insert = w_accept;
            end
        end
    end

    // Build the chain of cells
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic   w_left_gt;
            t_entry w_left;
            t_entry w_right;

            assign w_occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_left_gt = 1'b0;
                assign w_left    = w_req;
            end else begin : g_body
                assign w_left_gt = w_gt[g-1];
                assign w_left    = w_entry[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right = w_entry[g];
            end else begin : g_mid
                assign w_right = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_occ     (w_occ[g]),
                .i_left_gt (w_left_gt),
                .i_left    (w_left),
                .i_right   (w_right),
                .o_entry   (w_entry[g]),
                .o_gt      (w_gt[g]),
                .o_match   (w_match[g])
            );
        end
    endgenerate

    // Advance the count and hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_res_count <= n_count;
            r_res_entry <= n_res_entry;
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.status       = r_status;
    assign o_res.count        = COUNT_W'(r_res_count);
    assign o_res.out_handle   = r_res_entry.handle;
    assign o_res.out_kind     = r_res_entry.kind;
    assign o_res.out_priority = r_res_entry.prio;

    // Count stays within the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // Chain stays sorted: at most one insert boundary
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_gt & ~{w_gt[QUEUE_DEPTH-2:0], 1'b0}))
        else $error("cell chain out of priority order");

    // Successful insert grows the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

    // A removed head never carries the null handle
    a_remove_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.remove |=> r_res_entry.handle != '0)
        else $error("null handle removed from queue");

endmodule

[rtl/core/spq_cell.sv]
// Cell: one slot of the sorted chain, shifting entries to or from its neighbours.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_left_gt,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_gt,
    output logic      o_match
);

    t_entry r_entry;
    t_entry n_entry;

    // Flag slots that are free or hold a strictly larger priority
    assign o_gt    = !i_occ || (r_entry.prio > i_ctl.req.prio);
    assign o_match = i_occ && (r_entry.handle == i_ctl.req.handle);
    assign o_entry = r_entry;

    // Take the new entry at the boundary, shift right behind it, shift left on remove
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert && o_gt) begin
            n_entry = i_left_gt ? i_left : i_ctl.req;
        end else if (i_ctl.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
